[src/acss_pkg.sv]
// ----------------------------------------------------------------------------
// ADC channel scan sequencer package
// Phase codes, command codes and field widths shared by the scan sequencer.
// ----------------------------------------------------------------------------
package acss_pkg;

  // channel count default and field widths
  localparam int unsigned DefChannels = 8;
  localparam int unsigned ChanW       = 3;
  localparam int unsigned WordW       = 24;
  localparam int unsigned SettleW     = 16;
  localparam int unsigned FuncW       = 2;
  localparam int unsigned SelW        = 2;
  localparam int unsigned PhaseW      = 3;

  // stream widths (whole bytes)
  localparam int unsigned InDataW  = 32;
  localparam int unsigned OutDataW = 64;

  localparam logic [SettleW-1:0] SettleReset = 16'd2;
  localparam logic [SettleW-1:0] SettleMax   = 16'hFFFF;

  // command codes carried in tuser
  localparam logic [FuncW-1:0] FUNC_TICK    = 2'd0;
  localparam logic [FuncW-1:0] FUNC_HOLD    = 2'd1;
  localparam logic [FuncW-1:0] FUNC_RELEASE = 2'd2;

  // trigger and read select codes
  localparam logic [SelW-1:0] SEL_NONE    = 2'd0;
  localparam logic [SelW-1:0] SEL_CURRENT = 2'd1;
  localparam logic [SelW-1:0] SEL_VOLTAGE = 2'd2;

  // scan phases
  localparam logic [PhaseW-1:0] PH_IDLE   = 3'd0;
  localparam logic [PhaseW-1:0] PH_OPEN   = 3'd1;
  localparam logic [PhaseW-1:0] PH_SETTLE = 3'd2;
  localparam logic [PhaseW-1:0] PH_TRIG_I = 3'd3;
  localparam logic [PhaseW-1:0] PH_READ_I = 3'd4;
  localparam logic [PhaseW-1:0] PH_READ_V = 3'd5;
  localparam logic [PhaseW-1:0] PH_PARKED = 3'd6;

endpackage

[src/adc_channel_scan_sequencer.sv]
// ----------------------------------------------------------------------------
// ADC channel scan sequencer
// Tick-driven round-robin scan of analog channels through a mux and two
// converters, with hold (park) on a requested channel.
// ----------------------------------------------------------------------------
// Usage:
//   The slave stream carries one command per transaction: tuser holds the
//   command (tick, hold request, hold release), tdata holds the hold channel
//   and the converter word read back during that tick. Every accepted
//   transaction yields exactly one result transaction on the master stream
//   with the mux, converter and sample controls for that tick.
//   The result is registered: a command accepted at one edge shows its result
//   on the master stream right after that edge. Throughput is one command per
//   cycle while the receiver takes each result; the scan state and the result
//   register are updated together from a single pass of phase logic.
//   The cfg channel writes settle_ticks and is always ready; write it only
//   while no result is outstanding.
//   Reset puts the scan in idle at channel 0, clears any hold request and
//   sets settle_ticks to 2. When the receiver stalls, the result register
//   holds its transaction and s_axis_tready drops until it is taken.
// ----------------------------------------------------------------------------
module adc_channel_scan_sequencer
  import acss_pkg::*;
#(
  parameter int unsigned CHANNELS = DefChannels
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  // slave stream
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  input  logic [InDataW-1:0]  s_axis_tdata,   // ir_channel[2:0], adc_word[26:3]
  input  logic [FuncW-1:0]    s_axis_tuser,   // func[1:0]
  // master stream
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  output logic [OutDataW-1:0] m_axis_tdata,   // mux_reset[0], mux_open[1],
                                              // mux_channel[4:2], convert_start[5],
                                              // trigger_select[7:6], read_select[9:8],
                                              // sample_valid[10], sample_channel[13:11],
                                              // current_code[37:14], voltage_code[61:38],
                                              // parked[62]
  // configuration write
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [SettleW-1:0]  cfg_data_i
);

  localparam int unsigned ScanW = (CHANNELS > 8) ? 4 : 3;
  localparam logic [ScanW:0] ChanCount = (ScanW+1)'(CHANNELS);

  logic in_acc;
  logic out_acc;

  logic [PhaseW-1:0]  phase_q, phase_d;
  logic [SettleW-1:0] settle_count_q, settle_count_d;
  logic [SettleW-1:0] settle_ticks_q;
  logic [ScanW-1:0]   scan_channel_q, scan_channel_d;
  logic [ChanW-1:0]   hold_target_q, hold_target_d;
  logic               hold_pending_q, hold_pending_d;
  logic [WordW-1:0]   held_current_q, held_current_d;

  logic               out_valid_q;
  logic [OutDataW-1:0] out_data_q, out_data_d;

  logic [FuncW-1:0]  func;
  logic [ChanW-1:0]  ir_channel;
  logic [WordW-1:0]  adc_word;

  logic [ScanW-1:0]   next_chan;
  logic [ScanW:0]     chan_inc;
  logic [SettleW-1:0] settle_inc;

  // result fields
  logic               m_reset, m_open, conv, valid;
  logic [ScanW-1:0]   m_chan, s_chan;
  logic [SelW-1:0]    trig, rsel;
  logic [WordW-1:0]   i_code, v_code;

  assign func       = s_axis_tuser;
  assign ir_channel = s_axis_tdata[ChanW-1:0];
  assign adc_word   = s_axis_tdata[ChanW+WordW-1:ChanW];

  assign out_acc       = out_valid_q & m_axis_tready;
  assign s_axis_tready = ~out_valid_q | m_axis_tready;
  assign in_acc        = s_axis_tvalid & s_axis_tready;
  assign cfg_ready_o   = 1'b1;

  // wrap at the channel count
  assign chan_inc  = {1'b0, scan_channel_q} + 1'b1;
  assign next_chan = (chan_inc >= ChanCount) ? '0 : chan_inc[ScanW-1:0];

  assign settle_inc = (settle_count_q == SettleMax) ? settle_count_q
                                                    : settle_count_q + 1'b1;

  always_comb begin
    phase_d        = phase_q;
    settle_count_d = settle_count_q;
    scan_channel_d = scan_channel_q;
    hold_target_d  = hold_target_q;
    hold_pending_d = hold_pending_q;
    held_current_d = held_current_q;
    m_reset = 1'b0;
    m_open  = 1'b0;
    m_chan  = '0;
    conv    = 1'b0;
    trig    = SEL_NONE;
    rsel    = SEL_NONE;
    valid   = 1'b0;
    s_chan  = '0;
    i_code  = '0;
    v_code  = '0;

    unique case (func)
      FUNC_HOLD: begin
        hold_target_d  = ir_channel;
        hold_pending_d = 1'b1;
      end
      FUNC_RELEASE: begin
        hold_pending_d = 1'b0;
        m_reset        = 1'b1;
        phase_d        = PH_IDLE;
      end
      FUNC_TICK: begin
        unique case (phase_q)
          PH_IDLE: begin
            m_reset        = 1'b1;
            settle_count_d = '0;
            scan_channel_d = '0;
            phase_d        = PH_OPEN;
          end
          PH_OPEN: begin
            m_open = 1'b1;
            if (hold_pending_q) begin
              // park on the requested channel
              scan_channel_d = ScanW'(hold_target_q);
              m_chan         = ScanW'(hold_target_q);
              phase_d        = PH_PARKED;
            end else begin
              settle_count_d = '0;
              m_chan         = scan_channel_q;
              phase_d        = PH_SETTLE;
            end
          end
          PH_SETTLE: begin
            settle_count_d = settle_inc;
            if (settle_inc >= settle_ticks_q) begin
              conv           = 1'b1;
              settle_count_d = '0;
              phase_d        = PH_TRIG_I;
            end
          end
          PH_TRIG_I: begin
            m_reset = 1'b1;
            trig    = SEL_CURRENT;
            phase_d = PH_READ_I;
          end
          PH_READ_I: begin
            // read current, open ahead onto the next channel
            m_open         = 1'b1;
            m_chan         = next_chan;
            held_current_d = adc_word;
            rsel           = SEL_CURRENT;
            trig           = SEL_VOLTAGE;
            phase_d        = PH_READ_V;
          end
          PH_READ_V: begin
            rsel   = SEL_VOLTAGE;
            valid  = 1'b1;
            s_chan = scan_channel_q;
            i_code = held_current_q;
            v_code = adc_word;
            if (!hold_pending_q) begin
              scan_channel_d = next_chan;
              settle_count_d = settle_inc;
              phase_d        = PH_SETTLE;
            end else begin
              m_reset = 1'b1;
              phase_d = PH_OPEN;
            end
          end
          PH_PARKED: begin
          end
          default: begin
            phase_d = PH_IDLE;
          end
        endcase
      end
      default: begin
      end
    endcase

    out_data_d = {1'b0,
                  (phase_d == PH_PARKED),
                  v_code,
                  i_code,
                  s_chan[ChanW-1:0],
                  valid,
                  rsel,
                  trig,
                  conv,
                  m_chan[ChanW-1:0],
                  m_open,
                  m_reset};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q        <= PH_IDLE;
      settle_count_q <= '0;
      scan_channel_q <= '0;
      hold_target_q  <= '0;
      hold_pending_q <= 1'b0;
      settle_ticks_q <= SettleReset;
      out_valid_q    <= 1'b0;
    end else begin
      if (cfg_valid_i) begin
        settle_ticks_q <= cfg_data_i;
      end
      if (in_acc) begin
        phase_q        <= phase_d;
        settle_count_q <= settle_count_d;
        scan_channel_q <= scan_channel_d;
        hold_target_q  <= hold_target_d;
        hold_pending_q <= hold_pending_d;
        out_valid_q    <= 1'b1;
      end else if (out_acc) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      held_current_q <= held_current_d;
      out_data_q     <= out_data_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

  // every accepted command leaves a result behind
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> out_valid_q)
    else $error("accepted command produced no result");

  // a release always lands in idle with the hold cleared
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && func == FUNC_RELEASE |=> phase_q == PH_IDLE && !hold_pending_q)
    else $error("hold release did not return to idle");

  // a conversion start is followed by the current trigger phase
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && func == FUNC_TICK && conv |=> phase_q == PH_TRIG_I)
    else $error("conversion start without current trigger phase");

  // a current read is always followed by the voltage read phase
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && func == FUNC_TICK && phase_q == PH_READ_I |=> phase_q == PH_READ_V)
    else $error("current read not followed by voltage read");

endmodule
